// ----- rtl/yuvrgb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared widths, register map and pipeline control types for the YUV to RGB
// converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

   localparam int PIXEL_W    = 8;
   localparam int OFFSET_W   = 9;
   // luma minus offset spans -255..511
   localparam int Y_W        = 10;
   localparam int NUM_STAGES = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_LUMA_OFFSET = REG_IDX_W'(0);

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/yuvrgb_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_csr
// Register port holding the luma offset.
// ----------------------------------------------------------------------------
module yuvrgb_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [yuvrgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [yuvrgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [yuvrgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready,
   output logic signed [yuvrgb_pkg::OFFSET_W-1:0] luma_offset
);
   import yuvrgb_pkg::*;

   logic signed [OFFSET_W-1:0] luma_offset_ff;
   logic signed [OFFSET_W-1:0] luma_offset_in;
   logic [REG_IDX_W-1:0]       reg_idx;
   logic                       wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      luma_offset_in = luma_offset_ff;
      if (wr_en && (reg_idx == REG_LUMA_OFFSET)) begin
         luma_offset_in = csr_pwdata[OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_offset_ff <= '0;
      end else begin
         luma_offset_ff <= luma_offset_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_LUMA_OFFSET) begin
         csr_prdata = {{(CSR_DATA_W-OFFSET_W){1'b0}}, luma_offset_ff};
      end
   end

   assign luma_offset = luma_offset_ff;

endmodule
`default_nettype wire

// ----- rtl/yuvrgb_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_mac
// Offset subtract, coefficient multiply and channel sums in three registered
// stages.
// ----------------------------------------------------------------------------
module yuvrgb_mac #(
   parameter int COEF_FRAC_BITS = 16,
   parameter int SUM_W          = 30
) (
   input  wire logic                              clock,
   input  wire yuvrgb_pkg::pipe_ctl_type          pipe_ctl,
   input  wire logic signed [yuvrgb_pkg::OFFSET_W-1:0] luma_offset,
   input  wire logic [yuvrgb_pkg::PIXEL_W-1:0]    luma,
   input  wire logic [yuvrgb_pkg::PIXEL_W-1:0]    chroma_u,
   input  wire logic [yuvrgb_pkg::PIXEL_W-1:0]    chroma_v,
   output logic signed [SUM_W-1:0]                red_sum,
   output logic signed [SUM_W-1:0]                green_sum,
   output logic signed [SUM_W-1:0]                blue_sum
);
   import yuvrgb_pkg::*;

   // coefficients are below 2, so one integer bit plus sign
   localparam int  COEF_W = COEF_FRAC_BITS + 2;
   localparam int  PROD_W = COEF_W + Y_W;
   localparam longint ONE = longint'(1) << COEF_FRAC_BITS;

   localparam logic signed [COEF_W-1:0] K_RY =
      COEF_W'((1176 * ONE + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_RV =
      COEF_W'((127635 * ONE + 50000) / 100000);
   localparam logic signed [COEF_W-1:0] K_RB =
      COEF_W'((290891 * ONE + 5000000) / 10000000);
   localparam logic signed [COEF_W-1:0] K_GY =
      COEF_W'((117589 * ONE + 50000) / 100000);
   localparam logic signed [COEF_W-1:0] K_GU =
      COEF_W'((3127 * ONE + 5000) / 10000);
   localparam logic signed [COEF_W-1:0] K_GV =
      COEF_W'((635371 * ONE + 500000) / 1000000);
   localparam logic signed [COEF_W-1:0] K_GB =
      COEF_W'((105016 * ONE + 500000) / 1000000);
   localparam logic signed [COEF_W-1:0] K_BY =
      COEF_W'((117604 * ONE + 50000) / 100000);
   localparam logic signed [COEF_W-1:0] K_BU =
      COEF_W'((167181 * ONE + 50000) / 100000);
   localparam logic signed [COEF_W-1:0] K_BB =
      COEF_W'((511733 * ONE + 5000000) / 10000000);

   // stage 1
   logic signed [Y_W-1:0]     y_ff, y_in;
   logic signed [PIXEL_W-1:0] u_ff, v_ff;

   // stage 2
   logic signed [PROD_W-1:0] p_ry_ff, p_rv_ff;
   logic signed [PROD_W-1:0] p_gy_ff, p_gu_ff, p_gv_ff;
   logic signed [PROD_W-1:0] p_by_ff, p_bu_ff;

   // stage 3
   logic signed [SUM_W-1:0] r_ff, g_ff, b_ff;
   logic signed [SUM_W-1:0] r_in, g_in, b_in;

   assign y_in = Y_W'($signed({1'b0, luma})) - Y_W'(luma_offset);

   always_ff @(posedge clock) begin
      if (pipe_ctl.load[0]) begin
         y_ff <= y_in;
         u_ff <= chroma_u;
         v_ff <= chroma_v;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.load[1]) begin
         p_ry_ff <= PROD_W'(y_ff) * PROD_W'(K_RY);
         p_rv_ff <= PROD_W'(v_ff) * PROD_W'(K_RV);
         p_gy_ff <= PROD_W'(y_ff) * PROD_W'(K_GY);
         p_gu_ff <= PROD_W'(u_ff) * PROD_W'(K_GU);
         p_gv_ff <= PROD_W'(v_ff) * PROD_W'(K_GV);
         p_by_ff <= PROD_W'(y_ff) * PROD_W'(K_BY);
         p_bu_ff <= PROD_W'(u_ff) * PROD_W'(K_BU);
      end
   end

   always_comb begin
      r_in = SUM_W'(p_ry_ff) + SUM_W'(p_rv_ff) - SUM_W'(K_RB);
      g_in = SUM_W'(p_gy_ff) - SUM_W'(p_gu_ff) - SUM_W'(p_gv_ff) - SUM_W'(K_GB);
      b_in = SUM_W'(p_by_ff) + SUM_W'(p_bu_ff) - SUM_W'(K_BB);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.load[2]) begin
         r_ff <= r_in;
         g_ff <= g_in;
         b_ff <= b_in;
      end
   end

   assign red_sum   = r_ff;
   assign green_sum = g_ff;
   assign blue_sum  = b_ff;

endmodule
`default_nettype wire

// ----- rtl/yuvrgb_clamp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_clamp
// Output stage: floors each channel sum and clamps it to 0..255.
// ----------------------------------------------------------------------------
module yuvrgb_clamp #(
   parameter int COEF_FRAC_BITS = 16,
   parameter int SUM_W          = 30
) (
   input  wire logic                           clock,
   input  wire yuvrgb_pkg::pipe_ctl_type       pipe_ctl,
   input  wire logic signed [SUM_W-1:0]        red_sum,
   input  wire logic signed [SUM_W-1:0]        green_sum,
   input  wire logic signed [SUM_W-1:0]        blue_sum,
   output logic [yuvrgb_pkg::PIXEL_W-1:0]      red,
   output logic [yuvrgb_pkg::PIXEL_W-1:0]      green,
   output logic [yuvrgb_pkg::PIXEL_W-1:0]      blue
);
   import yuvrgb_pkg::*;

   logic [PIXEL_W-1:0] red_ff, green_ff, blue_ff;

   function automatic logic [PIXEL_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] s);
      logic               over;
      logic [PIXEL_W-1:0] res;
      // any integer bit above the byte means the floor is past 255
      over = |s[SUM_W-2:COEF_FRAC_BITS+PIXEL_W];
      res  = s[COEF_FRAC_BITS+PIXEL_W-1:COEF_FRAC_BITS];
      if (s[SUM_W-1]) begin
         res = '0;
      end else if (over) begin
         res = '1;
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (pipe_ctl.load[3]) begin
         red_ff   <= clamp_byte(red_sum);
         green_ff <= clamp_byte(green_sum);
         blue_ff  <= clamp_byte(blue_sum);
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule
`default_nettype wire

// ----- rtl/yuv_to_rgb_clamped.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_rgb_clamped
// Fixed-point YUV to RGB conversion with luma offset and 0..255 clamping.
// Four register stages lead from input transaction to result valid: offset
// subtract, multiply, channel sum, clamp. Throughput: one pixel per cycle
// while the output is not stalled; each stage refills as soon as it empties.
// Reset clears the stage valid bits and sets the luma offset to zero.
// ----------------------------------------------------------------------------
module yuv_to_rgb_clamped #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: luma [7:0], chroma_u [15:8], chroma_v [23:16]
   input  wire logic [23:0]                       req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: red [7:0], green [15:8], blue [23:16]
   output logic [23:0]                            rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [yuvrgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [yuvrgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [yuvrgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import yuvrgb_pkg::*;

   localparam int SUM_W = COEF_FRAC_BITS + Y_W + 4;

   logic signed [OFFSET_W-1:0] luma_offset;
   logic [NUM_STAGES-1:0]      valid_ff, valid_in;
   pipe_ctl_type               pipe_ctl;
   logic signed [SUM_W-1:0]    red_sum, green_sum, blue_sum;
   logic [PIXEL_W-1:0]         red, green, blue;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      pipe_ctl.load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         pipe_ctl.load[k] = !valid_ff[k] || pipe_ctl.load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pipe_ctl.load[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (pipe_ctl.load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = pipe_ctl.load[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {blue, green, red};

   yuvrgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .luma_offset (luma_offset)
   );

   yuvrgb_mac #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .SUM_W          (SUM_W)
   ) u_mac (
      .clock       (clock),
      .pipe_ctl    (pipe_ctl),
      .luma_offset (luma_offset),
      .luma        (req_tdata[7:0]),
      .chroma_u    (req_tdata[15:8]),
      .chroma_v    (req_tdata[23:16]),
      .red_sum     (red_sum),
      .green_sum   (green_sum),
      .blue_sum    (blue_sum)
   );

   yuvrgb_clamp #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .SUM_W          (SUM_W)
   ) u_clamp (
      .clock     (clock),
      .pipe_ctl  (pipe_ctl),
      .red_sum   (red_sum),
      .green_sum (green_sum),
      .blue_sum  (blue_sum),
      .red       (red),
      .green     (green),
      .blue      (blue)
   );

   // full pipeline with a stalled output must refuse new pixels
   assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline full and stalled");

   // a result only appears after the sum stage held a pixel
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(valid_ff[NUM_STAGES-2]))
      else $error("result valid without a pixel in the sum stage");

   // offset register takes the written data
   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
       && (csr_paddr[CSR_ADDR_W-1:2] == REG_LUMA_OFFSET))
      |=> (luma_offset == $past(csr_pwdata[OFFSET_W-1:0])))
      else $error("luma offset write lost");

endmodule
`default_nettype wire
